### rtl/core/rprc_pkg.sv
// Shared types and constants for the rectangle path recognizer and clipper.
package rprc_pkg;

  typedef enum logic [2:0] {
    REQ_BEGIN = 3'd0,
    REQ_CLIP  = 3'd1,
    REQ_MOVE  = 3'd2,
    REQ_LINE  = 3'd3,
    REQ_CURVE = 3'd4,
    REQ_CLOSE = 3'd5,
    REQ_END   = 3'd6,
    REQ_NONE  = 3'd7
  } req_t;

  typedef enum logic [4:0] {
    S_EMPTY, S_START, S_X, S_R, S_L, S_D, S_U,
    S_RD, S_RU, S_LD, S_LU, S_DR, S_DL, S_UR, S_UL,
    S_RDL, S_RUL, S_LDR, S_LUR, S_DRU, S_DLU, S_URD, S_ULD
  } path_t;

  typedef enum logic [2:0] {
    C_IDLE, C_READ, C_CALC, C_EMIT, C_STAT
  } ctl_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_OPEN  = 2'd2;
  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_RECT   = 1'b1;

endpackage

### rtl/core/rect_path_recognizer_clipper_unit.sv
// Top level: path command recognizer with clip store and rectangle emitter.
//
// Path commands other than close and end produce no output item. End answers
// one status item. A close that draws nothing answers only a status item. A
// close with no stored clip emits its rectangle and a status item. With clips
// it walks the clip memory one entry at a time (memory read, intersect, hand
// off the result) and then answers a status item. A stall on the result side
// holds the walk. The clip memory holds the clip rectangles in load order; only
// loaded entries are read.
module rect_path_recognizer_clipper_unit #(
  parameter int MAX_CLIPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic [15:0]        in_clip_width,
  input  logic [15:0]        in_clip_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_item_kind,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_rect_x,
  output logic signed [15:0] out_rect_y,
  output logic [15:0]        out_rect_w,
  output logic [15:0]        out_rect_h,
  output logic               out_last
);
  import rprc_pkg::*;

  localparam int AW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
  localparam int CW = $clog2(MAX_CLIPS + 1);

  // state
  ctl_t ctl_r, ctl_nxt;
  path_t ps_r;
  logic signed [15:0] cx_r, cy_r;
  logic [15:0] rw_r, rh_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic err_r;
  logic signed [17:0] tx_r, ty_r;
  logic [15:0] tw_r, th_r;
  logic [1:0] stat_r;

  // clip memory
  logic [63:0] mem [MAX_CLIPS];
  logic [63:0] rd_r;

  // output register
  logic ov_r, ok_r, ol_r;
  logic [1:0] os_r;
  logic signed [15:0] ox_r, oy_r;
  logic [15:0] ow_r, oh_r;

  assign out_valid = ov_r;
  assign out_item_kind = ok_r;
  assign out_status = os_r;
  assign out_rect_x = ox_r;
  assign out_rect_y = oy_r;
  assign out_rect_w = ow_r;
  assign out_rect_h = oh_r;
  assign out_last = ol_r;

  logic oslot;
  assign oslot = !ov_r || out_ready;
  assign in_ready = (ctl_r == C_IDLE);

  logic acc;
  req_t req;
  assign acc = in_valid && in_ready;
  assign req = req_t'(in_req_type);

  // line-to evaluation
  logic signed [16:0] px, py, cx, cy, w17, h17;
  logic ln_ok;
  path_t ln_ps;
  logic [15:0] ln_w, ln_h;
  always_comb begin
    px = {in_point_x[15], in_point_x};
    py = {in_point_y[15], in_point_y};
    cx = {cx_r[15], cx_r};
    cy = {cy_r[15], cy_r};
    w17 = {1'b0, rw_r};
    h17 = {1'b0, rh_r};
    ln_ok = 1'b1;
    ln_ps = ps_r;
    ln_w = rw_r;
    ln_h = rh_r;
    case (ps_r)
      S_START, S_X: begin
        if (px != cx && py != cy) ln_ok = 1'b0;
        else if (px > cx) begin
          ln_ps = (ps_r == S_START) ? S_R : S_DR;
          ln_w = 16'(px - cx);
        end else if (px < cx) begin
          ln_ps = (ps_r == S_START) ? S_L : S_DL;
          ln_w = 16'(cx - px);
        end else if (py > cy) begin
          ln_ps = (ps_r == S_START) ? S_D : S_RD;
          ln_h = 16'(py - cy);
        end else if (py < cy) begin
          ln_ps = (ps_r == S_START) ? S_U : S_RU;
          ln_h = 16'(cy - py);
        end else ln_ps = (ps_r == S_START) ? S_X : S_RD;
      end
      S_R, S_L: begin
        if (px != cx) ln_ok = 1'b0;
        else if (py > cy) begin
          ln_ps = (ps_r == S_R) ? S_RD : S_LD;
          ln_h = 16'(py - cy);
        end else begin
          ln_ps = (ps_r == S_R) ? S_RU : S_LU;
          ln_h = 16'(cy - py);
        end
      end
      S_D, S_U: begin
        if (py != cy) ln_ok = 1'b0;
        else if (px > cx) begin
          ln_ps = (ps_r == S_D) ? S_DR : S_UR;
          ln_w = 16'(px - cx);
        end else begin
          ln_ps = (ps_r == S_D) ? S_DL : S_UL;
          ln_w = 16'(cx - px);
        end
      end
      S_RD, S_RU: begin
        if (px != cx - w17 || py != cy) ln_ok = 1'b0;
        else ln_ps = (ps_r == S_RD) ? S_RDL : S_RUL;
      end
      S_LD, S_LU: begin
        if (px != cx + w17 || py != cy) ln_ok = 1'b0;
        else ln_ps = (ps_r == S_LD) ? S_LDR : S_LUR;
      end
      S_DR, S_DL: begin
        if (px != cx || py != cy - h17) ln_ok = 1'b0;
        else ln_ps = (ps_r == S_DR) ? S_DRU : S_DLU;
      end
      S_UR, S_UL: begin
        if (px != cx || py != cy + h17) ln_ok = 1'b0;
        else ln_ps = (ps_r == S_UR) ? S_URD : S_ULD;
      end
      default: ln_ok = 1'b0;
    endcase
  end

  // close evaluation: new current point (wrapped) and rectangle origin (unwrapped)
  logic cl_ok, cl_nop;
  logic signed [15:0] cl_cx, cl_cy;
  logic signed [17:0] cl_tx, cl_ty, cx18, cy18, w18, h18;
  always_comb begin
    cx18 = 18'(cx_r);
    cy18 = 18'(cy_r);
    w18 = {2'b0, rw_r};
    h18 = {2'b0, rh_r};
    cl_ok = 1'b1;
    cl_nop = 1'b0;
    cl_cx = cx_r;
    cl_cy = cy_r;
    cl_tx = cx18;
    cl_ty = cy18;
    case (ps_r)
      S_EMPTY, S_START: cl_nop = 1'b1;
      S_RDL: begin
        cl_cy = cy_r - rh_r; cl_tx = cx18; cl_ty = cy18 - h18;
      end
      S_LDR: begin
        cl_cy = cy_r - rh_r; cl_tx = cx18 - w18; cl_ty = cy18 - h18;
      end
      S_RUL: begin
        cl_cy = cy_r + rh_r; cl_tx = cx18; cl_ty = cy18;
      end
      S_LUR: begin
        cl_cy = cy_r + rh_r; cl_tx = cx18 - w18; cl_ty = cy18;
      end
      S_DRU: begin
        cl_cx = cx_r - rw_r; cl_tx = cx18 - w18; cl_ty = cy18;
      end
      S_URD: begin
        cl_cx = cx_r - rw_r; cl_tx = cx18 - w18; cl_ty = cy18 - h18;
      end
      S_DLU: begin
        cl_cx = cx_r + rw_r; cl_tx = cx18; cl_ty = cy18;
      end
      S_ULD: begin
        cl_cx = cx_r + rw_r; cl_tx = cx18; cl_ty = cy18 - h18;
      end
      default: cl_ok = 1'b0;
    endcase
  end

  // intersection of the pending rectangle with the clip just read
  // (the model keeps rectangle origin sign-extended, size unsigned)
  logic signed [17:0] l, t, r, b, x0, y0, x1, y1, ax, ay, ar, ab;
  logic hit;
  always_comb begin
    l  = 18'(signed'(rd_r[63:48]));
    t  = 18'(signed'(rd_r[47:32]));
    r  = l + 18'({2'b0, rd_r[31:16]});
    b  = t + 18'({2'b0, rd_r[15:0]});
    ax = tx_r;
    ay = ty_r;
    ar = ax + 18'({2'b0, tw_r});
    ab = ay + 18'({2'b0, th_r});
    x0 = (ax > l) ? ax : l;
    y0 = (ay > t) ? ay : t;
    x1 = (ar < r) ? ar : r;
    y1 = (ab < b) ? ab : b;
    hit = (x0 < x1) && (y0 < y1);
  end

  logic more;
  assign more = (idx_r < cnt_r);

  // next control state
  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      C_IDLE: begin
        if (acc && req == REQ_END) ctl_nxt = C_STAT;
        else if (acc && req == REQ_CLOSE) begin
          if (err_r || !cl_ok || cl_nop || rw_r == 16'd0 || rh_r == 16'd0)
            ctl_nxt = C_STAT;
          else if (cnt_r == '0) ctl_nxt = C_EMIT;
          else ctl_nxt = C_READ;
        end
      end
      C_READ: ctl_nxt = C_CALC;
      C_CALC: ctl_nxt = C_EMIT;
      C_EMIT: begin
        if (oslot) ctl_nxt = (cnt_r != '0 && more) ? C_READ : C_STAT;
      end
      C_STAT: if (oslot) ctl_nxt = C_IDLE;
      default: ctl_nxt = C_IDLE;
    endcase
  end

  // clip memory write and read
  always_ff @(posedge clk) begin
    if (acc && req == REQ_CLIP && !err_r && cnt_r < CW'(MAX_CLIPS))
      mem[cnt_r[AW-1:0]] <= {in_point_x, in_point_y, in_clip_width, in_clip_height};
    if (ctl_r == C_READ) rd_r <= mem[idx_r[AW-1:0]];
  end

  // control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= C_IDLE;
      ps_r <= S_EMPTY;
      cx_r <= '0; cy_r <= '0; rw_r <= '0; rh_r <= '0;
      cnt_r <= '0; idx_r <= '0; err_r <= 1'b0;
      stat_r <= ST_OK;
    end else begin
      ctl_r <= ctl_nxt;
      if (acc) begin
        case (req)
          REQ_BEGIN: begin
            ps_r <= S_EMPTY; cnt_r <= '0; err_r <= 1'b0;
          end
          REQ_CLIP: if (!err_r) begin
            if (cnt_r >= CW'(MAX_CLIPS)) err_r <= 1'b1;
            else cnt_r <= cnt_r + 1'b1;
          end
          REQ_MOVE: if (!err_r) begin
            if (ps_r != S_EMPTY && ps_r != S_START) err_r <= 1'b1;
            else begin
              cx_r <= in_point_x; cy_r <= in_point_y;
              rw_r <= '0; rh_r <= '0; ps_r <= S_START;
            end
          end
          REQ_LINE: if (!err_r) begin
            if (!ln_ok) err_r <= 1'b1;
            else begin
              ps_r <= ln_ps; rw_r <= ln_w; rh_r <= ln_h;
              cx_r <= in_point_x; cy_r <= in_point_y;
            end
          end
          REQ_CURVE: err_r <= 1'b1;
          REQ_CLOSE: begin
            idx_r <= '0;
            if (err_r) stat_r <= ST_ERR;
            else if (!cl_ok) begin
              err_r <= 1'b1; stat_r <= ST_ERR;
            end else begin
              stat_r <= ST_OK;
              if (!cl_nop) begin
                cx_r <= cl_cx; cy_r <= cl_cy;
                rw_r <= '0; rh_r <= '0; ps_r <= S_START;
              end
            end
          end
          REQ_END: begin
            if (err_r) stat_r <= ST_ERR;
            else if (ps_r == S_EMPTY || ps_r == S_START) stat_r <= ST_OK;
            else stat_r <= ST_OPEN;
          end
          default: ;
        endcase
      end
      if (ctl_r == C_CALC) idx_r <= idx_r + 1'b1;
    end
  end

  // hold the pending rectangle for the clip walk
  always_ff @(posedge clk) begin
    if (acc && req == REQ_CLOSE) begin
      tx_r <= cl_tx; ty_r <= cl_ty; tw_r <= rw_r; th_r <= rh_r;
    end
  end

  // result register: load on a free slot, drop on transfer
  logic hit_r;
  always_ff @(posedge clk) begin
    hit_r <= (ctl_r == C_CALC) ? hit : hit_r;
  end
  logic signed [17:0] hx0_r, hy0_r, hx1_r, hy1_r;
  always_ff @(posedge clk) begin
    if (ctl_r == C_CALC) begin
      hx0_r <= x0; hy0_r <= y0; hx1_r <= x1; hy1_r <= y1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= (ov_r && !out_ready) ||
                 (oslot && (ctl_r == C_STAT ||
                            (ctl_r == C_EMIT && (cnt_r == '0 || hit_r))));
  end

  always_ff @(posedge clk) begin
    if (oslot) begin
      if (ctl_r == C_STAT) begin
        ok_r <= KIND_STATUS; os_r <= stat_r; ol_r <= 1'b1;
        ox_r <= '0; oy_r <= '0; ow_r <= '0; oh_r <= '0;
      end else if (ctl_r == C_EMIT) begin
        ok_r <= KIND_RECT; os_r <= ST_OK; ol_r <= 1'b0;
        if (cnt_r == '0) begin
          ox_r <= tx_r[15:0]; oy_r <= ty_r[15:0]; ow_r <= tw_r; oh_r <= th_r;
        end else begin
          ox_r <= 16'(hx0_r); oy_r <= 16'(hy0_r);
          ow_r <= 16'(hx1_r - hx0_r); oh_r <= 16'(hy1_r - hy0_r);
        end
      end
    end
  end

endmodule
